// File: design/mmbf_pkg.sv
`timescale 1ns / 1ps
package mmbf_pkg;

  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_SEND  = 2'd2,
    ACT_RECV  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_HANDLE  = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_WOULD_BLOCK = 3'd3,
    ST_TABLE_FULL  = 3'd4,
    ST_SEQUENCE    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RREAD,
    S_RDATA,
    S_RESP
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] name_key;
    logic [3:0]  handle;
    logic [6:0]  msg_len;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  handle_out;
    logic [7:0]  data_out;
    logic        last;
  } rsp_t;

endpackage

// File: design/mmbf_ram.sv
`timescale 1ns / 1ps
module mmbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/multi_mailbox_byte_fifo.sv
`timescale 1ns / 1ps
// Mailbox table with one byte ring per slot (slot 0 is never handed out).
// Every request takes a table read, and a writeback when it changes the
// entry; close and send then end with the response transfer. Open scans
// the table one slot per cycle, and a receive of N bytes streams its
// bytes from the ring memory, each byte a ring read and then a transfer
// with last set on the final one. The request side stalls while an item is
// in work; a finished response waits in the output register without
// holding up the next request. No clearing pass is needed after reset.
module multi_mailbox_byte_fifo #(
  parameter int MAILBOXES  = 16,
  parameter int RING_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mmbf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mmbf_pkg::rsp_t rsp
);
  import mmbf_pkg::*;

  localparam int SW  = $clog2(MAILBOXES);
  localparam int PW  = $clog2(RING_DEPTH);
  localparam int FW  = $clog2(RING_DEPTH + 1);
  localparam int AW  = $clog2(MAILBOXES * RING_DEPTH);
  localparam int EW  = 32 + 8 + PW + PW + FW;

  state_t state, state_next;
  req_t   op;
  logic   used [MAILBOXES];
  logic [SW-1:0] idx, free_idx, rslot;
  logic          free_found;
  logic          send_active;
  logic [3:0]    send_slot;
  logic [6:0]    send_remaining;
  logic [6:0]    rcnt;
  logic [PW-1:0] rptr;
  rsp_t          res;

  // table memory ports
  logic          tbl_we, tbl_re;
  logic [SW-1:0] tbl_waddr, tbl_raddr;
  logic [EW-1:0] tbl_wdata, tbl_rdata;
  // ring memory ports
  logic          ring_we, ring_re;
  logic [AW-1:0] ring_waddr, ring_raddr;
  logic [7:0]    ring_wdata, ring_rdata;

  // entry fields as read
  logic [31:0]   e_key;
  logic [7:0]    e_uc;
  logic [PW-1:0] e_rp, e_wp;
  logic [FW-1:0] e_fill;
  assign {e_key, e_uc, e_rp, e_wp, e_fill} = tbl_rdata;

  // next values from the datapath
  logic [31:0]   w_key;
  logic [7:0]    w_uc;
  logic [PW-1:0] w_rp, w_wp;
  logic [FW-1:0] w_fill;
  assign tbl_wdata = {w_key, w_uc, w_rp, w_wp, w_fill};

  logic          accept, out_free, scan_end, start_rx;
  logic          used_set, used_clr;
  logic [SW-1:0] used_idx;
  logic [SW-1:0] idx_next, free_idx_next, rslot_next;
  logic          free_found_next;
  logic          send_active_next;
  logic [3:0]    send_slot_next;
  logic [6:0]    send_remaining_next, rcnt_next;
  logic [PW-1:0] rptr_next;
  rsp_t          res_next;
  logic          rsp_load;
  rsp_t          rsp_next;

  logic [SW-1:0] hs;
  logic          h_ok, match, cand_ok;
  logic [SW-1:0] cand;
  logic [6:0]    pending, avail;
  logic [7:0]    fill_sum;
  logic [PW:0]   rp_sum;
  logic [7:0]    uc_dec;
  logic [6:0]    rem_dec;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_addr(input logic [SW-1:0] s,
                                             input logic [PW-1:0] p);
    ring_addr = AW'(s) * AW'(RING_DEPTH) + AW'(p);
  endfunction

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign hs   = SW'(op.handle);
  assign h_ok = (op.handle != 4'd0) && (32'(op.handle) < MAILBOXES) && used[hs];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.action == ACT_OPEN) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_RESP;
        end
      end
      S_EXEC:  state_next = start_rx ? S_RREAD : S_RESP;
      S_RREAD: state_next = S_RDATA;
      S_RDATA: begin
        if (out_free) begin
          state_next = (rcnt == 7'd0) ? S_IDLE : S_RREAD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    tbl_we = 1'b0;  tbl_re = 1'b0;
    tbl_waddr = hs; tbl_raddr = SW'(req.handle);
    w_key = e_key;  w_uc = e_uc; w_rp = e_rp; w_wp = e_wp; w_fill = e_fill;
    ring_we = 1'b0; ring_re = 1'b0;
    ring_waddr = ring_addr(hs, e_wp);
    ring_wdata = op.data_byte;
    ring_raddr = ring_addr(rslot, rptr);
    used_set = 1'b0; used_clr = 1'b0; used_idx = hs;
    idx_next = idx; free_idx_next = free_idx; free_found_next = free_found;
    send_active_next = send_active;
    send_slot_next = send_slot;
    send_remaining_next = send_remaining;
    rcnt_next = rcnt; rptr_next = rptr; rslot_next = rslot;
    res_next = res;
    rsp_load = 1'b0;
    rsp_next = res;
    scan_end = 1'b0; start_rx = 1'b0;

    match   = used[idx] && (e_key == op.name_key);
    cand_ok = free_found || !used[idx];
    cand    = free_found ? free_idx : idx;
    pending = (send_active && send_slot == op.handle) ? send_remaining : 7'd0;
    avail   = (7'(e_fill) >= pending) ? 7'(e_fill) - pending : 7'd0;
    fill_sum = 8'(e_fill) + 8'(op.msg_len);
    rp_sum  = (PW+1)'(e_rp) + (PW+1)'(op.msg_len);
    uc_dec  = (e_uc != 8'd0) ? e_uc - 8'd1 : e_uc;
    rem_dec = (send_remaining != 7'd0) ? send_remaining - 7'd1 : send_remaining;

    res_next.handle_out = 4'd0;
    res_next.data_out   = 8'd0;
    res_next.last       = 1'b1;
    res_next.status     = ST_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          tbl_re = 1'b1;
          if (req.action == ACT_OPEN) begin
            tbl_raddr = SW'(1);
            idx_next = SW'(1);
            free_found_next = 1'b0;
          end
        end
      end
      // compare one slot per cycle, remember the lowest free one
      S_SCAN: begin
        if (match) begin
          tbl_we = 1'b1; tbl_waddr = idx;
          w_uc = (e_uc != 8'hff) ? e_uc + 8'd1 : e_uc;
          res_next.handle_out = 4'(idx);
          scan_end = 1'b1;
        end else if (idx == SW'(MAILBOXES - 1)) begin
          scan_end = 1'b1;
          if (cand_ok) begin
            tbl_we = 1'b1; tbl_waddr = cand;
            w_key = op.name_key; w_uc = 8'd1;
            w_rp = '0; w_wp = '0; w_fill = '0;
            used_set = 1'b1; used_idx = cand;
            res_next.handle_out = 4'(cand);
          end else begin
            res_next.status = ST_TABLE_FULL;
          end
        end else begin
          if (!free_found && !used[idx]) begin
            free_found_next = 1'b1;
            free_idx_next = idx;
          end
          idx_next = idx + SW'(1);
          tbl_re = 1'b1; tbl_raddr = idx + SW'(1);
        end
      end
      S_EXEC: begin
        case (op.action)
          ACT_CLOSE: begin
            if (!h_ok) begin
              res_next.status = ST_BAD_HANDLE;
            end else if (send_active && send_slot == op.handle) begin
              res_next.status = ST_SEQUENCE;
            end else begin
              tbl_we = 1'b1;
              w_uc = uc_dec;
              used_clr = (uc_dec == 8'd0);
            end
          end
          ACT_SEND: begin
            if (send_active) begin
              if (op.handle != send_slot) begin
                res_next.status = ST_SEQUENCE;
              end else begin
                tbl_we = 1'b1; ring_we = 1'b1;
                w_wp = ptr_inc(e_wp);
                send_remaining_next = rem_dec;
                send_active_next = (rem_dec != 7'd0);
              end
            end else if (!h_ok) begin
              res_next.status = ST_BAD_HANDLE;
            end else if (op.msg_len > 7'(RING_DEPTH)) begin
              res_next.status = ST_TOO_LONG;
            end else if (fill_sum > 8'(RING_DEPTH)) begin
              res_next.status = ST_WOULD_BLOCK;
            end else if (op.msg_len != 7'd0) begin
              // reserve the whole message, store its first byte
              tbl_we = 1'b1; ring_we = 1'b1;
              w_fill = FW'(fill_sum);
              w_wp = ptr_inc(e_wp);
              send_slot_next = op.handle;
              send_remaining_next = op.msg_len - 7'd1;
              send_active_next = (op.msg_len != 7'd1);
            end
          end
          ACT_RECV: begin
            if (!h_ok) begin
              res_next.status = ST_BAD_HANDLE;
            end else if (op.msg_len > 7'(RING_DEPTH)) begin
              res_next.status = ST_TOO_LONG;
            end else if (op.msg_len > avail) begin
              res_next.status = ST_WOULD_BLOCK;
            end else if (op.msg_len != 7'd0) begin
              // consume now, then stream the bytes out
              tbl_we = 1'b1;
              w_rp = (rp_sum >= (PW+1)'(RING_DEPTH)) ?
                     PW'(rp_sum - (PW+1)'(RING_DEPTH)) : PW'(rp_sum);
              w_fill = e_fill - FW'(op.msg_len);
              start_rx = 1'b1;
              rslot_next = hs;
              rptr_next = e_rp;
              rcnt_next = op.msg_len;
            end
          end
          default: res_next.status = ST_OK;
        endcase
      end
      S_RREAD: begin
        ring_re = 1'b1;
        rptr_next = ptr_inc(rptr);
        rcnt_next = rcnt - 7'd1;
      end
      S_RDATA: begin
        if (out_free) begin
          rsp_load = 1'b1;
          rsp_next.status = ST_OK;
          rsp_next.handle_out = 4'd0;
          rsp_next.data_out = ring_rdata;
          rsp_next.last = (rcnt == 7'd0);
        end
      end
      S_RESP: begin
        // hold the finished result until the output register frees up
        res_next = res;
        if (out_free) begin
          rsp_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      send_active <= 1'b0;
      send_slot <= 4'd0;
      send_remaining <= 7'd0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < MAILBOXES; i++) begin
        used[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      send_active <= send_active_next;
      send_slot <= send_slot_next;
      send_remaining <= send_remaining_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (used_set) begin
        used[used_idx] <= 1'b1;
      end else if (used_clr) begin
        used[used_idx] <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= req;
    end
    idx <= idx_next;
    free_idx <= free_idx_next;
    free_found <= free_found_next;
    rcnt <= rcnt_next;
    rptr <= rptr_next;
    rslot <= rslot_next;
    res <= res_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  mmbf_ram #(.WIDTH(EW), .DEPTH(MAILBOXES)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  mmbf_ram #(.WIDTH(8), .DEPTH(MAILBOXES * RING_DEPTH)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .re(ring_re), .raddr(ring_raddr), .rdata(ring_rdata)
  );

endmodule

// File: design/mmbf_check.sv
`timescale 1ns / 1ps
module mmbf_check (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input mmbf_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input mmbf_pkg::rsp_t rsp
);
  import mmbf_pkg::*;

  // a stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed under stall");

  // errors are single transfers
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last)
    else $error("error response without last");

  // a granted handle comes only from a successful open
  a_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.handle_out != 4'd0 |-> rsp.status == ST_OK && rsp.last)
    else $error("handle granted on a failed or multi transfer");

  // data only travels with good status
  a_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.data_out != 8'd0 |-> rsp.status == ST_OK)
    else $error("data on an error response");

endmodule

bind multi_mailbox_byte_fifo mmbf_check u_check (.*);
